FILE: rtl/kfli_pkg.sv
// ----------------------------------------------------------------------------
// kfli_pkg: shared types and constants for the keyframe interpolator
// Command codes, table sizing and the queue entry type.
// ----------------------------------------------------------------------------
package kfli_pkg;

   localparam int MAX_KEYS = 16;
   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam logic [16:0] OPACITY_ONE = 17'd65536;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] time_in;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] angle_in;
      logic [31:0] opacity_in;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/kfli_queue.sv
// ----------------------------------------------------------------------------
// kfli_queue: two-entry queue between front and back
// Parts the input handshake from the execution engine.
// ----------------------------------------------------------------------------
module kfli_queue
   import kfli_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store on transfer
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && cnt_ff < 2'd2) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !out_valid) else $error("empty valid");

endmodule

FILE: rtl/kfli_engine.sv
// ----------------------------------------------------------------------------
// kfli_engine: keyframe table and interpolation engine
// Appends keyframes, scans one entry a cycle, divides one bit a cycle when
// the query lies between two keyframes, then multiplies one channel a cycle.
// ----------------------------------------------------------------------------
module kfli_engine
   import kfli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   output logic        item_ready,
   input  item_type    item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_valid,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_angle,
   output logic [16:0] rsp_out_opacity,
   output logic [31:0] rsp_duration,
   output logic [4:0]  rsp_key_total,
   output logic        rsp_table_full
);

   // keyframe memory: one row holds time, x, y, angle, opacity
   logic [159:0] mem [MAX_KEYS];
   logic [159:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      last_time_ff, last_time_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [159:0]     prev_ff, prev_in;
   logic [159:0]     next_ff, next_in;
   logic [31:0]      qtime_ff, qtime_in;
   logic             interp_ff, interp_in;
   logic [47:0]      rem_ff, rem_in;
   logic [15:0]      alpha_ff, alpha_in;
   logic [4:0]       step_ff, step_in;
   logic [1:0]       chan_ff, chan_in;
   logic [31:0]      res_ff [4];
   logic [31:0]      res_in [4];
   logic             valid_ff, valid_in;
   logic             full_ff, full_in;
   logic             write_en;
   logic [31:0]      den;
   logic [48:0]      trial;
   logic signed [32:0] diff;
   logic signed [49:0] prod;
   logic signed [33:0] lerp;
   logic signed [31:0] opv;

   assign item_ready = (state_ff == ST_IDLE);
   assign write_en   = item_valid && item_ready && item.command == CMD_APPEND
                       && count_ff < CNT_W'(MAX_KEYS);
   assign rd_addr    = scan_ff[IDX_W-1:0];

   // table write and registered read
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[count_ff[IDX_W-1:0]] <= {item.time_in, item.pos_x, item.pos_y,
                                      item.angle_in, item.opacity_in};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.command == CMD_QUERY && count_ff != '0) state_in = ST_SCAN;
               else state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (rd_pend_ff && (rd_data_ff[159:128] > qtime_ff
                               || scan_ff == count_ff)) begin
               state_in = interp_in ? ST_DIV : ST_MUL;
            end
         end
         ST_DIV:  if (step_ff == 5'd15) state_in = ST_MUL;
         ST_MUL:  if (chan_ff == 2'd3) state_in = ST_DONE;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign den   = next_ff[159:128] - prev_ff[159:128];
   assign trial = {rem_ff, 1'b0} - {17'd0, den};
   assign diff  = $signed({next_ff[32*(3-chan_ff)+31], next_ff[32*(3-chan_ff) +: 32]})
                - $signed({prev_ff[32*(3-chan_ff)+31], prev_ff[32*(3-chan_ff) +: 32]});
   assign prod  = diff * $signed({1'b0, alpha_ff});
   assign lerp  = $signed({{2{prev_ff[32*(3-chan_ff)+31]}}, prev_ff[32*(3-chan_ff) +: 32]})
                + $signed(prod[49:16]);

   // datapath updates
   always_comb begin
      count_in     = count_ff;
      last_time_in = last_time_ff;
      scan_in      = scan_ff;
      rd_pend_in   = rd_pend_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      qtime_in     = qtime_ff;
      interp_in    = interp_ff;
      rem_in       = rem_ff;
      alpha_in     = alpha_ff;
      step_in      = step_ff;
      chan_in      = chan_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      full_in      = full_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_in    = '0;
            rd_pend_in = 1'b0;
            qtime_in   = item.time_in;
            valid_in   = 1'b0;
            full_in    = 1'b0;
            interp_in  = 1'b0;
            chan_in    = 2'd0;
            step_in    = 5'd0;
            res_in     = '{default: 32'd0};
            if (item_valid) begin
               if (item.command == CMD_APPEND) begin
                  if (write_en) begin
                     count_in     = count_ff + 1'b1;
                     last_time_in = item.time_in;
                  end else begin
                     full_in = 1'b1;
                  end
               end else begin
                  valid_in = (count_ff != '0);
               end
            end
         end
         ST_SCAN: begin
            // data for scan_ff-1 arrives; stop at first later time or end
            rd_pend_in = 1'b1;
            scan_in    = scan_ff + 1'b1;
            if (rd_pend_ff) begin
               if (scan_ff == count_ff && rd_data_ff[159:128] <= qtime_ff) begin
                  prev_in   = rd_data_ff;
                  rd_pend_in = 1'b0;
               end else if (rd_data_ff[159:128] > qtime_ff) begin
                  next_in    = rd_data_ff;
                  interp_in  = (scan_ff != CNT_W'(1));
                  if (scan_ff == CNT_W'(1)) prev_in = rd_data_ff;
                  rd_pend_in = 1'b0;
               end else begin
                  prev_in = rd_data_ff;
               end
            end
            rem_in = {16'd0, qtime_ff - prev_in[159:128]};
            if (!interp_in) alpha_in = 16'd0;
            if (!interp_in) next_in = prev_in;
         end
         ST_DIV: begin
            // restoring division: one quotient bit per cycle
            if (step_ff == 5'd0) rem_in = {16'd0, qtime_ff - prev_ff[159:128]};
            if (!trial[48]) begin
               rem_in   = trial[47:0];
               alpha_in = {alpha_ff[14:0], 1'b1};
            end else begin
               rem_in   = {rem_ff[46:0], 1'b0};
               alpha_in = {alpha_ff[14:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
         end
         ST_MUL: begin
            res_in[chan_ff] = lerp[31:0];
            chan_in = chan_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
      last_time_ff <= last_time_in;
      scan_ff   <= scan_in;
      prev_ff   <= prev_in;
      next_ff   <= next_in;
      qtime_ff  <= qtime_in;
      interp_ff <= interp_in;
      rem_ff    <= rem_in;
      alpha_ff  <= alpha_in;
      step_ff   <= step_in;
      chan_ff   <= chan_in;
      res_ff    <= res_in;
      valid_ff  <= valid_in;
      full_ff   <= full_in;
   end

   // clamp opacity and drive the result
   assign opv = $signed(res_ff[3]);
   always_comb begin
      rsp_valid       = (state_ff == ST_DONE);
      rsp_frame_valid = valid_ff;
      rsp_out_x       = res_ff[0];
      rsp_out_y       = res_ff[1];
      rsp_out_angle   = res_ff[2];
      if (opv < 0) rsp_out_opacity = 17'd0;
      else if (opv > $signed({15'd0, OPACITY_ONE})) rsp_out_opacity = OPACITY_ONE;
      else rsp_out_opacity = opv[16:0];
      rsp_duration    = (count_ff != '0) ? last_time_ff : 32'd0;
      rsp_key_total   = 5'(count_ff);
      rsp_table_full  = full_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEYS)) else $error("count overflow");
   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> !rsp_frame_valid) else $error("full flag");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");

endmodule

FILE: rtl/keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator: piecewise linear keyframe interpolation
// Front queue plus a table-and-interpolate engine.
// ----------------------------------------------------------------------------
// An append is taken in the idle state and its result is presented in the
// done state. A query on a non-empty table is taken in the idle state, then
// scans the table with one memory read per cycle and stops at the first
// keyframe later than the query time or at the end of the table. Between two
// keyframes it computes the 16-bit alpha by bit-serial division. It then
// does a multiply-add for each of the four channels, one channel per cycle,
// and presents the result; a query on an empty table goes straight to the
// result. The result is held while rsp_ready stays low. A two-entry queue
// takes new items while the engine works. Results: one per item, in order.
module keyframe_linear_interpolator
   import kfli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_time_in,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_angle_in,
   input  logic [31:0] req_opacity_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_valid,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_angle,
   output logic [16:0] rsp_out_opacity,
   output logic [31:0] rsp_duration,
   output logic [4:0]  rsp_key_total,
   output logic        rsp_table_full
);

   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item = '{command: req_command, time_in: req_time_in, pos_x: req_pos_x,
                      pos_y: req_pos_y, angle_in: req_angle_in,
                      opacity_in: req_opacity_in};

   kfli_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   kfli_engine u_engine (
      .clock, .reset,
      .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
      .rsp_valid, .rsp_ready, .rsp_frame_valid, .rsp_out_x, .rsp_out_y,
      .rsp_out_angle, .rsp_out_opacity, .rsp_duration, .rsp_key_total,
      .rsp_table_full
   );

endmodule
